FILE: src/svdc_pkg.sv
// shared types and constants for the sparse vector dominance check
package svdc_pkg;

	// action field codes
	localparam int unsigned ACTION_BITS = 2;
	localparam logic [ACTION_BITS-1:0] ACT_LOAD_X  = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_LOAD_Y  = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_COMPARE = 2'd2;

	// tolerance register width
	localparam int unsigned TOL_BITS = 31;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EVAL
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic start;
		logic step;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic walk_done;
		logic out_busy;
	} status_t;

endpackage

FILE: src/svdc_if.sv
// request and result channel interfaces for the dominance check
interface svdc_req_if #(
	parameter int INDEX_BITS = 16,
	parameter int VALUE_BITS = 32
) ();
	logic                             valid;
	logic                             ready;
	logic [svdc_pkg::ACTION_BITS-1:0] action;
	logic [INDEX_BITS-1:0]            entry_index;
	logic signed [VALUE_BITS-1:0]     entry_value;

	modport source (output valid, action, entry_index, entry_value, input ready);
	modport sink (input valid, action, entry_index, entry_value, output ready);
endinterface

interface svdc_rsp_if ();
	logic valid;
	logic ready;
	logic dominates_flag;
	logic overflow_flag;

	modport source (output valid, dominates_flag, overflow_flag, input ready);
	modport sink (input valid, dominates_flag, overflow_flag, output ready);
endinterface

FILE: src/sparse_vector_dominance_check_unit.sv
// top level of the sparse vector dominance check
//
// Requests arrive on req (valid/ready) with an action, entry_index and
// entry_value. Action 0 appends an entry to list x, action 1 to list y,
// action 2 compares and clears, action 3 is taken and ignored. Indices are
// expected ascending within each list; missing coordinates count as zero.
// A load into a full list is dropped and remembered in overflow_flag.
// Loads are taken whenever the block is idle. A compare walks the merged
// lists in merge steps of a store read, then an evaluate, with merge steps
// at most x count + y count; the next load can be taken in the cycle the
// result first shows on rsp. Only compares produce a result. The result
// sits in an output register: loads keep being taken while it waits on
// rsp.ready, and a new compare is held off until it is taken. tolerance
// is written through cfg_we / cfg_wdata, which the user must do only while
// the block is idle; the block does not enforce this. Reset empties both
// lists, clears the lost-load flag and the tolerance; store contents are
// left as they are and only written entries are read.
module sparse_vector_dominance_check_unit #(
	parameter int CAPACITY   = 256,
	parameter int INDEX_BITS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [svdc_pkg::TOL_BITS-1:0] cfg_wdata,
	svdc_req_if.sink                      req,
	svdc_rsp_if.source                    rsp
);

	svdc_pkg::cmd_t    cmd;
	svdc_pkg::status_t sts;

	// controller
	svdc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath
	svdc_datapath #(
		.CAPACITY   (CAPACITY),
		.INDEX_BITS (INDEX_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_action    (req.action),
		.req_index     (req.entry_index),
		.req_value     (req.entry_value),
		.cmd           (cmd),
		.sts           (sts),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.rsp_dominates (rsp.dominates_flag),
		.rsp_overflow  (rsp.overflow_flag)
	);

endmodule

FILE: src/svdc_ctrl.sv
// controller state machine for loads and the merge walk
module svdc_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  logic [svdc_pkg::ACTION_BITS-1:0] req_action,
	output logic                             req_ready,
	input  svdc_pkg::status_t                sts,
	output svdc_pkg::cmd_t                   cmd
);

	svdc_pkg::state_t state_q, state_d;
	logic is_compare;
	logic is_load;
	logic accept;

	// request decode
	assign is_compare = (req_action == svdc_pkg::ACT_COMPARE);
	assign is_load    = (req_action == svdc_pkg::ACT_LOAD_X) ||
	                    (req_action == svdc_pkg::ACT_LOAD_Y);
	assign req_ready  = (state_q == svdc_pkg::ST_IDLE) && !(is_compare && sts.out_busy);
	assign accept     = req_valid && req_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svdc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			svdc_pkg::ST_IDLE: begin
				if (accept && is_compare) state_d = svdc_pkg::ST_FETCH;
			end
			svdc_pkg::ST_FETCH: begin
				state_d = sts.walk_done ? svdc_pkg::ST_IDLE : svdc_pkg::ST_EVAL;
			end
			svdc_pkg::ST_EVAL: begin
				state_d = svdc_pkg::ST_FETCH;
			end
			default: begin
				state_d = svdc_pkg::ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			svdc_pkg::ST_IDLE: begin
				cmd.load  = accept && is_load;
				cmd.start = accept && is_compare;
			end
			svdc_pkg::ST_FETCH: begin
				cmd.finish = sts.walk_done;
			end
			svdc_pkg::ST_EVAL: begin
				cmd.step = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// at most one command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.start, cmd.step, cmd.finish}))
		else $error("more than one datapath command at once");

	// a walk starts only with the result register free
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !sts.out_busy)
		else $error("compare started while a result is pending");

	// every evaluation is followed by a fetch
	a_eval_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == svdc_pkg::ST_EVAL |=> state_q == svdc_pkg::ST_FETCH)
		else $error("evaluation not followed by fetch");

endmodule

FILE: src/svdc_datapath.sv
// entry stores, counters, merge compare and result register
module svdc_datapath #(
	parameter int CAPACITY   = 256,
	parameter int INDEX_BITS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [svdc_pkg::TOL_BITS-1:0]    cfg_wdata,
	input  logic [svdc_pkg::ACTION_BITS-1:0] req_action,
	input  logic [INDEX_BITS-1:0]            req_index,
	input  logic signed [VALUE_BITS-1:0]     req_value,
	input  svdc_pkg::cmd_t                   cmd,
	output svdc_pkg::status_t                sts,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic                             rsp_dominates,
	output logic                             rsp_overflow
);

	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int WIDE     = (VALUE_BITS > svdc_pkg::TOL_BITS) ? VALUE_BITS : svdc_pkg::TOL_BITS;
	localparam int CW       = WIDE + 2;
	localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(CAPACITY);

	// entry stores
	logic [INDEX_BITS-1:0] x_idx_mem [CAPACITY];
	logic [VALUE_BITS-1:0] x_val_mem [CAPACITY];
	logic [INDEX_BITS-1:0] y_idx_mem [CAPACITY];
	logic [VALUE_BITS-1:0] y_val_mem [CAPACITY];

	logic [INDEX_BITS-1:0] x_idx_rd_q, y_idx_rd_q;
	logic [VALUE_BITS-1:0] x_val_rd_q, y_val_rd_q;

	logic [CNT_BITS-1:0] x_cnt_q, y_cnt_q, i_q, j_q;
	logic                lost_q, ok_q, out_valid_q, out_dom_q, out_ovf_q;
	logic [svdc_pkg::TOL_BITS-1:0] tol_q;

	logic load_x, load_y, x_full, y_full;
	logic xv, yv, take_x, take_y, take_both, adv_i, adv_j;
	logic [VALUE_BITS-1:0] op_a, op_b;
	logic signed [CW-1:0] sum_a, ext_b;
	logic below;

	// load decode
	assign load_x = cmd.load && (req_action == svdc_pkg::ACT_LOAD_X);
	assign load_y = cmd.load && (req_action == svdc_pkg::ACT_LOAD_Y);
	assign x_full = (x_cnt_q == FULL);
	assign y_full = (y_cnt_q == FULL);

	// store writes and registered reads at the walk pointers
	always_ff @(posedge clk) begin
		if (load_x && !x_full) begin
			x_idx_mem[x_cnt_q[AW-1:0]] <= req_index;
			x_val_mem[x_cnt_q[AW-1:0]] <= req_value;
		end
		if (load_y && !y_full) begin
			y_idx_mem[y_cnt_q[AW-1:0]] <= req_index;
			y_val_mem[y_cnt_q[AW-1:0]] <= req_value;
		end
		x_idx_rd_q <= x_idx_mem[i_q[AW-1:0]];
		x_val_rd_q <= x_val_mem[i_q[AW-1:0]];
		y_idx_rd_q <= y_idx_mem[j_q[AW-1:0]];
		y_val_rd_q <= y_val_mem[j_q[AW-1:0]];
	end

	// merge step selection
	assign xv        = (i_q < x_cnt_q);
	assign yv        = (j_q < y_cnt_q);
	assign take_both = xv && yv && (x_idx_rd_q == y_idx_rd_q);
	assign take_x    = xv && (!yv || (x_idx_rd_q < y_idx_rd_q));
	assign take_y    = yv && (!xv || (y_idx_rd_q < x_idx_rd_q));
	assign adv_i     = take_x || take_both;
	assign adv_j     = take_y || take_both;
	assign op_a      = adv_i ? x_val_rd_q : '0;
	assign op_b      = adv_j ? y_val_rd_q : '0;

	// exact test a + tol < b in widened signed arithmetic
	assign sum_a = CW'($signed(op_a)) + $signed({{(CW-svdc_pkg::TOL_BITS){1'b0}}, tol_q});
	assign ext_b = CW'($signed(op_b));
	assign below = (sum_a < ext_b);

	assign sts.walk_done = !xv && !yv;
	assign sts.out_busy  = out_valid_q;

	// counters, walk pointers and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_cnt_q     <= '0;
			y_cnt_q     <= '0;
			lost_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			ok_q        <= 1'b1;
			out_valid_q <= 1'b0;
			tol_q       <= '0;
		end else begin
			if (cfg_we) tol_q <= cfg_wdata;
			if (load_x) begin
				if (x_full) lost_q <= 1'b1;
				else x_cnt_q <= x_cnt_q + 1'b1;
			end
			if (load_y) begin
				if (y_full) lost_q <= 1'b1;
				else y_cnt_q <= y_cnt_q + 1'b1;
			end
			if (cmd.start) begin
				i_q  <= '0;
				j_q  <= '0;
				ok_q <= 1'b1;
			end
			if (cmd.step) begin
				if (adv_i) i_q <= i_q + 1'b1;
				if (adv_j) j_q <= j_q + 1'b1;
				if (below) ok_q <= 1'b0;
			end
			if (rsp_valid && rsp_ready) out_valid_q <= 1'b0;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				x_cnt_q     <= '0;
				y_cnt_q     <= '0;
				lost_q      <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_dom_q <= ok_q;
			out_ovf_q <= lost_q;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign rsp_dominates = out_dom_q;
	assign rsp_overflow  = out_ovf_q;

	// fill counts never pass capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(x_cnt_q <= FULL) && (y_cnt_q <= FULL))
		else $error("fill count beyond capacity");

	// a finished compare empties both lists and the lost flag
	a_finish_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (x_cnt_q == '0) && (y_cnt_q == '0) && !lost_q && out_valid_q)
		else $error("lists not cleared after compare");

	// walk pointers stay within the stored lists
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (i_q <= x_cnt_q) && (j_q <= y_cnt_q))
		else $error("walk pointer past end of list");

endmodule

FILE: verif/tb_sparse_vector_dominance_check_unit.sv
// self-checking testbench for the sparse vector dominance check unit
module tb_sparse_vector_dominance_check_unit;

	localparam int CAPACITY     = 256;
	localparam int LIMIT_CYCLES = 400000;
	localparam logic [svdc_pkg::ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

	// sequence flavors for the random part
	localparam int SEQ_CLEAN  = 0;
	localparam int SEQ_EDGE   = 1;
	localparam int SEQ_NOISY  = 2;
	localparam int SEQ_BROKEN = 3;

	typedef struct packed {
		logic [svdc_pkg::ACTION_BITS-1:0] action;
		logic [15:0]                      index;
		logic signed [31:0]               value;
	} vec_req_t;

	typedef struct packed {
		logic dominates;
		logic overflow;
	} verdict_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [svdc_pkg::TOL_BITS-1:0] cfg_wdata;

	svdc_req_if #(.INDEX_BITS(16), .VALUE_BITS(32)) req_bus ();
	svdc_rsp_if rsp_bus ();

	sparse_vector_dominance_check_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	vec_req_t req_queue[$];
	verdict_t verdict_queue[$];
	logic     req_fired;
	bit       steady;
	int       mismatch_count;

	// shadow copy of the two lists and the tolerance
	logic [15:0]        x_idx[CAPACITY];
	logic signed [31:0] x_val[CAPACITY];
	logic [15:0]        y_idx[CAPACITY];
	logic signed [31:0] y_val[CAPACITY];
	int                 x_fill;
	int                 y_fill;
	logic               dropped_load;
	longint             tol_model;

	always #2 clk = ~clk;

	function automatic vec_req_t make_req(logic [svdc_pkg::ACTION_BITS-1:0] a,
			logic [15:0] i, logic signed [31:0] v);
		vec_req_t r;
		r.action = a;
		r.index  = i;
		r.value  = v;
		return r;
	endfunction

	// append a request to the pending queue
	task automatic enqueue(vec_req_t r);
		req_queue.insert(req_queue.size(), r);
	endtask

	// true when a + tolerance < b
	function automatic logic falls_short(longint a, longint b);
		return (b - a) > tol_model;
	endfunction

	// merge walk over both lists in index order, missing entries are zero
	function automatic logic walk_dominates();
		int   i;
		int   j;
		logic ok;
		i  = 0;
		j  = 0;
		ok = 1'b1;
		while (i < x_fill && j < y_fill) begin
			if (x_idx[i] < y_idx[j]) begin
				if (falls_short(x_val[i], 0)) ok = 1'b0;
				i++;
			end else if (x_idx[i] == y_idx[j]) begin
				if (falls_short(x_val[i], y_val[j])) ok = 1'b0;
				i++;
				j++;
			end else begin
				if (falls_short(0, y_val[j])) ok = 1'b0;
				j++;
			end
		end
		while (i < x_fill) begin
			if (falls_short(x_val[i], 0)) ok = 1'b0;
			i++;
		end
		while (j < y_fill) begin
			if (falls_short(0, y_val[j])) ok = 1'b0;
			j++;
		end
		return ok;
	endfunction

	// advance the shadow state by one accepted request
	task automatic apply_request(vec_req_t r);
		verdict_t v;
		unique case (r.action)
			svdc_pkg::ACT_LOAD_X: begin
				if (x_fill < CAPACITY) begin
					x_idx[x_fill] = r.index;
					x_val[x_fill] = r.value;
					x_fill++;
				end else begin
					dropped_load = 1'b1;
				end
			end
			svdc_pkg::ACT_LOAD_Y: begin
				if (y_fill < CAPACITY) begin
					y_idx[y_fill] = r.index;
					y_val[y_fill] = r.value;
					y_fill++;
				end else begin
					dropped_load = 1'b1;
				end
			end
			svdc_pkg::ACT_COMPARE: begin
				v.dominates = walk_dominates();
				v.overflow  = dropped_load;
				verdict_queue.insert(verdict_queue.size(), v);
				x_fill       = 0;
				y_fill       = 0;
				dropped_load = 1'b0;
			end
			default: ;
		endcase
	endtask

	function automatic logic signed [31:0] clamp_q16(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] random_q16();
		unique case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
			2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $signed({{8{$urandom_range(0, 1) == 1}}, 24'($urandom)});
		endcase
	endfunction

	// slack kept at or above the pass boundary, now and then one short of it
	function automatic longint edge_margin(bit slips);
		if (slips && $urandom_range(0, 15) == 0) return -1;
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1 << 20);
		return $urandom_range(0, 2);
	endfunction

	// queue loads for both vectors, interleaved, followed by a compare
	task automatic queue_sequence(int nx, int ny, int flavor);
		vec_req_t           xs[$];
		vec_req_t           ys[$];
		int                 cur;
		int                 pick;
		bit                 has_x;
		bit                 has_y;
		bit                 slips;
		logic [15:0]        idx;
		logic signed [31:0] xv;
		logic signed [31:0] yv;
		cur   = $urandom_range(0, 65535 - 4 * (nx + ny) - 4);
		slips = flavor == SEQ_EDGE;
		while (xs.size() < nx || ys.size() < ny) begin
			has_x = xs.size() < nx;
			has_y = ys.size() < ny;
			if (has_x && has_y) begin
				pick  = $urandom_range(0, 2);
				has_x = pick != 1;
				has_y = pick != 0;
			end
			if (flavor == SEQ_NOISY || flavor == SEQ_BROKEN) begin
				xv = random_q16();
				yv = random_q16();
			end else if (has_x && has_y) begin
				yv = random_q16();
				xv = clamp_q16(yv - tol_model + edge_margin(slips));
			end else begin
				xv = clamp_q16(edge_margin(slips) - tol_model);
				yv = clamp_q16(tol_model - edge_margin(slips));
			end
			// broken lists: unordered, often repeated coordinates
			if (flavor == SEQ_BROKEN)
				idx = $urandom_range(0, 1) ? 16'($urandom_range(0, 7))
					: 16'($urandom_range(0, 65535));
			else
				idx = 16'(cur);
			if (has_x) xs.insert(xs.size(), make_req(svdc_pkg::ACT_LOAD_X, idx, xv));
			if (has_y) ys.insert(ys.size(), make_req(svdc_pkg::ACT_LOAD_Y, idx, yv));
			cur += $urandom_range(1, 4);
		end
		while (xs.size() != 0 || ys.size() != 0) begin
			if ($urandom_range(0, 24) == 0)
				enqueue(make_req(ACT_UNUSED, 16'($urandom), $urandom));
			if (ys.size() == 0 || (xs.size() != 0 && $urandom_range(0, 1) == 1))
				enqueue(xs.pop_front());
			else
				enqueue(ys.pop_front());
		end
		enqueue(make_req(svdc_pkg::ACT_COMPARE, 16'($urandom), $urandom));
	endtask

	task automatic random_phase(int budget);
		int spent;
		int roll;
		int nx;
		int ny;
		int flavor;
		spent = 0;
		while (spent < budget) begin
			roll = $urandom_range(0, 99);
			nx   = $urandom_range(0, 8);
			ny   = $urandom_range(0, 8);
			if (roll < 45) flavor = SEQ_CLEAN;
			else if (roll < 75) flavor = SEQ_EDGE;
			else if (roll < 90) flavor = SEQ_NOISY;
			else flavor = SEQ_BROKEN;
			queue_sequence(nx, ny, flavor);
			spent += nx + ny + 1;
		end
	endtask

	// wait until every request is taken and every verdict is checked
	task automatic settle(int tail);
		while (req_queue.size() != 0 || req_bus.valid || verdict_queue.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [svdc_pkg::TOL_BITS-1:0] t);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= t;
		@(negedge clk);
		cfg_we    <= 1'b0;
		tol_model = longint'(t);
	endtask

	// request driver
	always @(negedge clk) begin
		vec_req_t pick;
		if (arst_n) begin
			if (!req_bus.valid || req_fired) begin
				if (req_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 9)) begin
					pick = req_queue.pop_front();
					req_bus.valid       <= 1'b1;
					req_bus.action      <= pick.action;
					req_bus.entry_index <= pick.index;
					req_bus.entry_value <= pick.value;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		if (arst_n)
			rsp_bus.ready <= steady || $urandom_range(0, 99) >= 9;
	end

	// result checker and request monitor
	always @(posedge clk) begin
		verdict_t want;
		req_fired <= req_bus.valid && req_bus.ready;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (verdict_queue.size() == 0) begin
					$display("%0t: unexpected result, actual dominates %0b overflow %0b",
						$time, rsp_bus.dominates_flag, rsp_bus.overflow_flag);
					mismatch_count++;
				end else begin
					want = verdict_queue.pop_front();
					if (rsp_bus.dominates_flag !== want.dominates) begin
						$display("%0t: dominates_flag expected %0b actual %0b",
							$time, want.dominates, rsp_bus.dominates_flag);
						mismatch_count++;
					end
					if (rsp_bus.overflow_flag !== want.overflow) begin
						$display("%0t: overflow_flag expected %0b actual %0b",
							$time, want.overflow, rsp_bus.overflow_flag);
						mismatch_count++;
					end
				end
			end
			if (req_bus.valid && req_bus.ready)
				apply_request(make_req(req_bus.action, req_bus.entry_index,
					req_bus.entry_value));
		end
	end

	// run limit
	initial begin
		#(LIMIT_CYCLES * 4);
		$display("sparse_vector_dominance_check_unit regression: fail");
		$finish;
	end

	// stimulus
	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_bus.valid       = 1'b0;
		req_bus.action      = svdc_pkg::ACT_LOAD_X;
		req_bus.entry_index = '0;
		req_bus.entry_value = '0;
		rsp_bus.ready       = 1'b0;
		req_fired           = 1'b0;
		steady              = 1'b0;
		mismatch_count      = 0;
		x_fill              = 0;
		y_fill              = 0;
		dropped_load        = 1'b0;
		tol_model           = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty lists
		enqueue(make_req(svdc_pkg::ACT_COMPARE, 16'h0000, 32'sh0));
		// field extremes, dominating
		enqueue(make_req(svdc_pkg::ACT_LOAD_X, 16'h0000, 32'sh7FFFFFFF));
		enqueue(make_req(svdc_pkg::ACT_LOAD_Y, 16'h0000, 32'sh80000000));
		enqueue(make_req(svdc_pkg::ACT_COMPARE, 16'hFFFF, 32'shFFFFFFFF));
		// field extremes, failing, with ignored actions in between
		enqueue(make_req(svdc_pkg::ACT_LOAD_X, 16'hFFFF, 32'sh80000000));
		enqueue(make_req(ACT_UNUSED, 16'hFFFF, 32'sh80000000));
		enqueue(make_req(svdc_pkg::ACT_LOAD_Y, 16'hFFFF, 32'sh7FFFFFFF));
		enqueue(make_req(ACT_UNUSED, 16'h0000, 32'sh7FFFFFFF));
		enqueue(make_req(svdc_pkg::ACT_COMPARE, 16'h0000, 32'sh0));
		// unordered and repeated coordinates
		enqueue(make_req(svdc_pkg::ACT_LOAD_X, 16'd5, 32'sh00010000));
		enqueue(make_req(svdc_pkg::ACT_LOAD_X, 16'd3, -32'sh00008000));
		enqueue(make_req(svdc_pkg::ACT_LOAD_X, 16'd3, 32'sh00020000));
		enqueue(make_req(svdc_pkg::ACT_LOAD_Y, 16'd3, 32'sh00010000));
		enqueue(make_req(svdc_pkg::ACT_LOAD_Y, 16'd5, 32'sh00010000));
		enqueue(make_req(svdc_pkg::ACT_COMPARE, 16'd0, 32'sh0));
		// lone negative x, lone positive y
		enqueue(make_req(svdc_pkg::ACT_LOAD_X, 16'd1, -32'sd1));
		enqueue(make_req(svdc_pkg::ACT_COMPARE, 16'd0, 32'sh0));
		enqueue(make_req(svdc_pkg::ACT_LOAD_Y, 16'd2, 32'sd1));
		enqueue(make_req(svdc_pkg::ACT_COMPARE, 16'd0, 32'sh0));
		// equal values at a shared coordinate
		enqueue(make_req(svdc_pkg::ACT_LOAD_Y, 16'd9, -32'sd7));
		enqueue(make_req(svdc_pkg::ACT_LOAD_X, 16'd9, -32'sd7));
		enqueue(make_req(svdc_pkg::ACT_COMPARE, 16'd0, 32'sh0));
		settle(8);

		// largest tolerance
		write_tolerance(31'h7FFFFFFF);
		random_phase(70);
		settle(8);

		// one lsb of slack, x list overfilled
		write_tolerance(31'd1);
		random_phase(70);
		queue_sequence(CAPACITY + 2, 2, SEQ_CLEAN);
		settle(8);

		// one unit of slack, no idling on either side
		steady = 1'b1;
		write_tolerance(31'h00010000);
		random_phase(70);
		settle(8);
		steady = 1'b0;

		// random slack, y list overfilled
		write_tolerance(31'($urandom));
		queue_sequence(3, CAPACITY + 1, SEQ_CLEAN);
		random_phase(70);
		settle(8);

		// no slack
		write_tolerance(31'd0);
		random_phase(70);
		settle(40);

		if (mismatch_count == 0)
			$display("sparse_vector_dominance_check_unit regression: pass");
		else
			$display("sparse_vector_dominance_check_unit regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
src/svdc_pkg.sv
src/svdc_if.sv
src/svdc_ctrl.sv
src/svdc_datapath.sv
src/sparse_vector_dominance_check_unit.sv
verif/tb_sparse_vector_dominance_check_unit.sv
